// ===== rtl/lru_pkg.sv =====
package lru_pkg;

    localparam int NUM_FRAMES = 10;
    localparam int PAGE_BITS  = 16;

    localparam int IN_PAGE_W  = 16;
    localparam int STAMP_W    = 32;
    localparam int FAULT_W    = 32;
    localparam int FRAME_W    = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    localparam int CNT_W      = $clog2(NUM_FRAMES + 1);
    localparam int OUT_W      = 56;

    typedef logic [PAGE_BITS-1:0] t_page;
    typedef logic [STAMP_W-1:0]   t_stamp;
    typedef logic [FRAME_W-1:0]   t_frame;
    typedef logic [CNT_W-1:0]     t_count;

    typedef struct packed {
        t_page  page;
        t_stamp stamp;
    } t_entry;

    // Keep the low PAGE_BITS bits of the incoming page number.
    function automatic t_page to_page(logic [IN_PAGE_W-1:0] x);
        logic [63:0] ext;
        ext = {48'b0, x};
        return ext[PAGE_BITS-1:0];
    endfunction

    // Fit a stored page into the 16-bit result field.
    function automatic logic [IN_PAGE_W-1:0] to_field(t_page p);
        logic [63:0] ext;
        ext = 64'(p);
        return ext[IN_PAGE_W-1:0];
    endfunction

    function automatic logic [31:0] sat_inc(logic [31:0] v);
        return (v == '1) ? v : v + 32'd1;
    endfunction

endpackage

// ===== rtl/lru_page_replacement.sv =====
// An accepted beat is scanned against the used frames, one entry per cycle through
// the single read port of the frame memory, and is then written back while its
// result beat is loaded. A new reference is taken only once the previous one has
// been written back and its result loaded.
// Reset (i_rst_n low, synchronous) empties the frame set and clears both counters.
module lru_page_replacement
    import lru_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [15:0]          i_s_axis_tdata,   // [15:0] page_number
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [OUT_W-1:0]     o_m_axis_tdata    // [0] hit, [1] evicted_valid,
                                                   // [17:2] evicted_page,
                                                   // [49:18] fault_total, rest zero
);

    // The controller is a three-state sequencer. IDLE takes a reference beat,
    // SCAN streams the used frames out of the memory one per cycle and compares
    // each against the page while tracking the oldest stamp, and WRITE commits
    // the updated entry and loads the result register.
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_WRITE = 2'd2;

    logic [1:0]   r_state, n_state;

    // Frame memory: one entry per frame, holding the page and its last
    // reference time. Reads are registered. The write in
    // WRITE always finishes before the next scan starts, so reads and writes
    // of the same entry never overlap and no forwarding is needed.
    t_entry       r_mem [NUM_FRAMES];
    t_entry       r_rd_data;
    logic         rd_en;
    logic         wr_en;
    t_frame       wr_addr;
    t_entry       wr_data;

    // Per-reference working registers.
    t_page        r_page;
    t_stamp       r_time;
    logic [FAULT_W-1:0] r_faults;
    t_count       r_used;

    // Scan pipeline: r_idx is the next address to issue, r_cmp_idx names the
    // entry whose data is on the memory output when r_cmp_vld is set.
    t_count       r_idx;
    logic         r_cmp_vld;
    t_frame       r_cmp_idx;

    logic         r_hit;
    t_frame       r_hit_idx;
    t_stamp       r_min_stamp;
    t_frame       r_min_idx;
    t_page        r_min_page;

    // Result register. It frees the input side while a result waits.
    logic         r_out_vld;
    logic         r_out_hit;
    logic         r_out_ev_vld;
    logic [15:0]  r_out_ev_page;
    logic [FAULT_W-1:0] r_out_faults;

    logic         in_acc;
    logic         out_free;
    logic         frames_full;
    logic         scan_done;
    logic         commit;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free        = !r_out_vld || i_m_axis_tready;
    assign frames_full     = (r_used == CNT_W'(NUM_FRAMES));
    assign scan_done       = (r_idx == r_used);
    assign commit          = (r_state == S_WRITE) && out_free;
    assign rd_en           = (r_state == S_SCAN) && (r_idx < r_used);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (scan_done) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Choose the entry to update. A hit refreshes the matching frame, a miss
    // fills the next free frame, and with every frame taken the oldest one is
    // replaced.
    always_comb begin
        wr_en         = commit;
        wr_data.page  = r_page;
        wr_data.stamp = r_time;
        if (r_hit) begin
            wr_addr = r_hit_idx;
        end else if (!frames_full) begin
            wr_addr = r_used[FRAME_W-1:0];
        end else begin
            wr_addr = r_min_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[r_idx[FRAME_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_time    <= '0;
            r_faults  <= '0;
            r_used    <= '0;
            r_idx     <= '0;
            r_cmp_vld <= 1'b0;
            r_hit     <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;

            if (in_acc) begin
                r_time    <= sat_inc(r_time);
                r_idx     <= '0;
                r_cmp_vld <= 1'b0;
                r_hit     <= 1'b0;
            end

            if (r_state == S_SCAN) begin
                if (rd_en) begin
                    r_idx     <= r_idx + CNT_W'(1);
                    r_cmp_vld <= 1'b1;
                end else begin
                    r_cmp_vld <= 1'b0;
                end
                // The first matching frame wins.
                if (r_cmp_vld && !r_hit && (r_rd_data.page == r_page)) begin
                    r_hit <= 1'b1;
                end
            end

            if (commit) begin
                if (!r_hit) begin
                    r_faults <= sat_inc(r_faults);
                    if (!frames_full) begin
                        r_used <= r_used + CNT_W'(1);
                    end
                end
            end

            if (commit) begin
                r_out_vld <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Payload registers, no reset needed.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_page <= to_page(i_s_axis_tdata);
        end

        if ((r_state == S_SCAN) && rd_en) begin
            r_cmp_idx <= r_idx[FRAME_W-1:0];
        end

        if ((r_state == S_SCAN) && r_cmp_vld) begin
            if (!r_hit && (r_rd_data.page == r_page)) begin
                r_hit_idx <= r_cmp_idx;
            end
            // Strict less-than keeps the lowest index on equal stamps.
            if ((r_cmp_idx == '0) || (r_rd_data.stamp < r_min_stamp)) begin
                r_min_stamp <= r_rd_data.stamp;
                r_min_idx   <= r_cmp_idx;
                r_min_page  <= r_rd_data.page;
            end
        end

        if (commit) begin
            r_out_hit    <= r_hit;
            r_out_ev_vld <= !r_hit && frames_full;
            r_out_faults <= r_hit ? r_faults : sat_inc(r_faults);
            if (!r_hit && frames_full) begin
                r_out_ev_page <= to_field(r_min_page);
            end else begin
                r_out_ev_page <= '0;
            end
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {6'b0, r_out_faults, r_out_ev_page, r_out_ev_vld, r_out_hit};

endmodule
